/* rtl/core/pdpa_pkg.sv */
// Shared types, constants and tables of the pose delta progress accumulator.
package pdpa_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_QMUL,
        S_DRAIN,
        S_QRND,
        S_SQ,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_CINIT,
        S_CORDIC,
        S_ANGLE,
        S_RPROD,
        S_RMAT,
        S_TPROD,
        S_TDIFF,
        S_NORM,
        S_TSQ,
        S_DIST,
        S_ADD,
        S_DONE
    } state_t;

    // accumulate command, registered with the product in the cycle after the multiplier issue
    typedef struct packed {
        logic       en;
        logic       clr;
        logic       neg;
        logic [3:0] dst;
    } acc_op_t;

    typedef struct packed {
        logic [1:0] a_idx;
        logic [1:0] b_idx;
        logic       neg;
    } rterm_t;

    localparam int ROOT_BITS    = 32;
    localparam int ROOT_CNT_W   = $clog2(ROOT_BITS);
    localparam int CORDIC_STEPS = 24;

    localparam logic [1:0] Q_W = 2'd0;
    localparam logic [1:0] Q_X = 2'd1;
    localparam logic [1:0] Q_Y = 2'd2;
    localparam logic [1:0] Q_Z = 2'd3;

    localparam logic signed [31:0] HALF_PI_Q24 = 32'sd26353589;

    // sign of each term of q_last * conj(q_cur), index component*4 + term
    localparam logic [15:0] QNEG_MASK = 16'h3950;

    function automatic logic signed [31:0] sext16(input logic signed [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic signed [31:0] cordic_angle(input logic [4:0] i);
        logic signed [31:0] a;
        case (i)
            5'd0:    a = 32'sd13176795;
            5'd1:    a = 32'sd7778716;
            5'd2:    a = 32'sd4110060;
            5'd3:    a = 32'sd2086331;
            5'd4:    a = 32'sd1047214;
            5'd5:    a = 32'sd524117;
            5'd6:    a = 32'sd262123;
            5'd7:    a = 32'sd131069;
            5'd8:    a = 32'sd65536;
            5'd9:    a = 32'sd32768;
            5'd10:   a = 32'sd16384;
            5'd11:   a = 32'sd8192;
            5'd12:   a = 32'sd4096;
            5'd13:   a = 32'sd2048;
            5'd14:   a = 32'sd1024;
            5'd15:   a = 32'sd512;
            5'd16:   a = 32'sd256;
            5'd17:   a = 32'sd128;
            5'd18:   a = 32'sd64;
            5'd19:   a = 32'sd32;
            5'd20:   a = 32'sd16;
            5'd21:   a = 32'sd8;
            5'd22:   a = 32'sd4;
            5'd23:   a = 32'sd2;
            default: a = 32'sd0;
        endcase
        return a;
    endfunction

    // two product terms per rotation matrix entry, row major
    function automatic rterm_t rprod_term(input logic [4:0] k);
        rterm_t t;
        case (k)
            5'd0:    t = '{Q_Y, Q_Y, 1'b0};
            5'd1:    t = '{Q_Z, Q_Z, 1'b0};
            5'd2:    t = '{Q_X, Q_Y, 1'b0};
            5'd3:    t = '{Q_W, Q_Z, 1'b1};
            5'd4:    t = '{Q_X, Q_Z, 1'b0};
            5'd5:    t = '{Q_W, Q_Y, 1'b0};
            5'd6:    t = '{Q_X, Q_Y, 1'b0};
            5'd7:    t = '{Q_W, Q_Z, 1'b0};
            5'd8:    t = '{Q_X, Q_X, 1'b0};
            5'd9:    t = '{Q_Z, Q_Z, 1'b0};
            5'd10:   t = '{Q_Y, Q_Z, 1'b0};
            5'd11:   t = '{Q_W, Q_X, 1'b1};
            5'd12:   t = '{Q_X, Q_Z, 1'b0};
            5'd13:   t = '{Q_W, Q_Y, 1'b1};
            5'd14:   t = '{Q_Y, Q_Z, 1'b0};
            5'd15:   t = '{Q_W, Q_X, 1'b0};
            5'd16:   t = '{Q_X, Q_X, 1'b0};
            5'd17:   t = '{Q_Y, Q_Y, 1'b0};
            default: t = '{Q_W, Q_W, 1'b0};
        endcase
        return t;
    endfunction

    function automatic logic rmat_diag(input logic [3:0] e);
        return (e == 4'd0) || (e == 4'd4) || (e == 4'd8);
    endfunction

endpackage

/* rtl/core/pdpa_isqrt.sv */
// Bit-serial floor square root of a 64-bit value, one root bit per cycle.
module pdpa_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import pdpa_pkg::*;

    logic [63:0]           rad_reg;
    logic [35:0]           rem_reg;
    logic [31:0]           root_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        fits;

    assign rem_sh = {rem_reg[33:0], rad_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ROOT_CNT_W'(ROOT_BITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

/* rtl/core/pose_delta_progress_accumulator.sv */
// Sequence: restart, invalid or first pose go straight to the done state; a rotation step
// and a distance step (halving passes vary) are set by the shared 32x32 multiplier
// issue sequence, the bit-serial square root and 24 CORDIC steps.
// Throughput: one item at a time; input stalls until the result is in the output register.
// Reset: asynchronous, active low; progress, start value and stored-pose flag cleared.
module pose_delta_progress_accumulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic signed [31:0]  wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                restart,
    input  logic                pose_valid,
    input  logic                pure_translation,
    input  logic signed [15:0]  quat_w,
    input  logic signed [15:0]  quat_x,
    input  logic signed [15:0]  quat_y,
    input  logic signed [15:0]  quat_z,
    input  logic signed [31:0]  trans_x,
    input  logic signed [31:0]  trans_y,
    input  logic signed [31:0]  trans_z,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                estimate_valid,
    output logic signed [47:0]  estimate
);
    import pdpa_pkg::*;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [4:0] cnt_reg, cnt_next;

    logic                have_reg;
    logic signed [47:0]  progress_reg;
    logic signed [31:0]  start_reg;
    logic signed [15:0]  lq_reg [4];
    logic signed [31:0]  lt_reg [3];
    logic signed [15:0]  cq_reg [4];
    logic signed [31:0]  ct_reg [3];
    logic                pure_reg;
    logic                resv_reg;

    logic signed [31:0]  mul_a, mul_b;
    logic signed [63:0]  prod_w, prod_reg;
    acc_op_t             op_reg, op_next;
    logic signed [63:0]  acc_reg [9];
    logic [3:0]          rd_idx;
    logic signed [63:0]  acc_rd, acc_add, acc_sum;

    logic signed [15:0]  qr_reg [4];
    logic signed [31:0]  rs_reg [9];
    logic [1:0]          col_reg, row_reg;
    logic [38:0]         m_reg [3];
    logic [3:0]          s_reg;
    logic signed [39:0]  x_reg, y_reg;
    logic signed [31:0]  z_reg;
    logic [39:0]         delta_reg;

    logic                out_valid_reg, est_valid_reg;
    logic signed [47:0]  est_reg;

    logic                root_start, root_done;
    logic [31:0]         root_val;

    logic                accept, any_high, out_free;
    logic signed [63:0]  rnd64, sh64, r64, rr64, t64;
    logic signed [15:0]  rnd16;
    logic signed [39:0]  d40, nd40, xs, ys;
    logic signed [16:0]  w17;
    logic [16:0]         xa;
    logic signed [31:0]  h32;
    logic signed [32:0]  hd33;
    logic signed [49:0]  sum50;
    logic signed [47:0]  sat48;
    rterm_t              rterm;
    logic [1:0]          sq_idx;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_free = !out_valid_reg || !out_stall;
    assign any_high = (m_reg[0][38:31] != '0) || (m_reg[1][38:31] != '0) ||
                      (m_reg[2][38:31] != '0);

    pdpa_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (acc_rd),
        .done     (root_done),
        .root     (root_val)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = '0;
                    if (restart || !pose_valid || !have_reg)
                        state_next = S_DONE;
                    else
                        state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd15)
                begin
                    cnt_next   = '0;
                    ret_next   = S_QRND;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
                state_next = ret_reg;
            S_QRND:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd3)
                begin
                    cnt_next   = '0;
                    state_next = pure_reg ? S_RPROD : S_SQ;
                end
            end
            S_SQ, S_TSQ:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                begin
                    cnt_next   = '0;
                    ret_next   = S_ROOT_GO;
                    state_next = S_DRAIN;
                end
            end
            S_ROOT_GO:
                state_next = S_ROOT_WAIT;
            S_ROOT_WAIT:
            begin
                if (root_done)
                    state_next = pure_reg ? S_DIST : S_CINIT;
            end
            S_CINIT:
            begin
                cnt_next   = '0;
                state_next = S_CORDIC;
            end
            S_CORDIC:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE, S_DIST:
                state_next = S_ADD;
            S_RPROD:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd17)
                begin
                    cnt_next   = '0;
                    ret_next   = S_RMAT;
                    state_next = S_DRAIN;
                end
            end
            S_RMAT:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd8)
                begin
                    cnt_next   = '0;
                    state_next = S_TPROD;
                end
            end
            S_TPROD:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd8)
                begin
                    cnt_next   = '0;
                    ret_next   = S_TDIFF;
                    state_next = S_DRAIN;
                end
            end
            S_TDIFF:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd2)
                begin
                    cnt_next   = '0;
                    state_next = S_NORM;
                end
            end
            S_NORM:
            begin
                if (!any_high)
                begin
                    cnt_next   = '0;
                    state_next = S_TSQ;
                end
            end
            S_ADD:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // ---------------- multiplier issue ----------------
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        op_next = '0;
        rterm   = rprod_term(cnt_reg);
        sq_idx  = cnt_reg[1:0] + 2'd1;
        unique case (state_reg)
            S_QMUL:
            begin
                mul_a   = sext16(lq_reg[cnt_reg[1:0]]);
                mul_b   = sext16(cq_reg[cnt_reg[3:2] ^ cnt_reg[1:0]]);
                op_next = '{1'b1, cnt_reg[1:0] == 2'd0, QNEG_MASK[cnt_reg[3:0]],
                            {2'b00, cnt_reg[3:2]}};
            end
            S_SQ:
            begin
                mul_a   = sext16(qr_reg[sq_idx]);
                mul_b   = sext16(qr_reg[sq_idx]);
                op_next = '{1'b1, cnt_reg == 5'd0, 1'b0, 4'd0};
            end
            S_RPROD:
            begin
                mul_a   = sext16(qr_reg[rterm.a_idx]);
                mul_b   = sext16(qr_reg[rterm.b_idx]);
                op_next = '{1'b1, !cnt_reg[0], rterm.neg, cnt_reg[4:1]};
            end
            S_TPROD:
            begin
                mul_a   = rs_reg[cnt_reg[3:0]];
                mul_b   = ct_reg[col_reg];
                op_next = '{1'b1, col_reg == 2'd0, 1'b0, {2'b00, row_reg}};
            end
            S_TSQ:
            begin
                mul_a   = {1'b0, m_reg[cnt_reg[1:0]][30:0]};
                mul_b   = {1'b0, m_reg[cnt_reg[1:0]][30:0]};
                op_next = '{1'b1, cnt_reg == 5'd0, 1'b0, 4'd0};
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                op_next = '0;
            end
        endcase
    end

    assign root_start = state_reg == S_ROOT_GO;
    assign prod_w     = mul_a * mul_b;
    assign rd_idx     = op_reg.en ? op_reg.dst : cnt_reg[3:0];
    assign acc_rd     = acc_reg[rd_idx];
    assign acc_add    = op_reg.neg ? -prod_reg : prod_reg;
    assign acc_sum    = (op_reg.clr ? 64'sd0 : acc_rd) + acc_add;

    // ---------------- datapath arithmetic ----------------
    always_comb
    begin
        rnd64 = acc_rd + 64'sd16384;
        sh64  = rnd64 >>> 15;
        if (sh64 > 64'sd32767)
            rnd16 = 16'sh7FFF;
        else if (sh64 < -64'sd32768)
            rnd16 = 16'sh8000;
        else
            rnd16 = sh64[15:0];

        r64  = rmat_diag(cnt_reg[3:0]) ? (64'sd1073741824 - (acc_rd <<< 1))
                                       : (acc_rd <<< 1);
        rr64 = (r64 + 64'sd4) >>> 3;

        t64  = (acc_rd + 64'sd67108864) >>> 27;
        d40  = {{8{lt_reg[cnt_reg[1:0]][31]}}, lt_reg[cnt_reg[1:0]]} - t64[39:0];
        nd40 = -d40;

        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;

        w17 = {qr_reg[0][15], qr_reg[0]};
        xa  = w17[16] ? 17'(-w17) : 17'(w17);

        // half angle with the zero-vector and zero-scalar cases
        if (root_val == '0)
            h32 = 32'sd0;
        else if (xa == '0)
            h32 = HALF_PI_Q24;
        else if (z_reg < 32'sd0)
            h32 = 32'sd0;
        else if (z_reg > HALF_PI_Q24)
            h32 = HALF_PI_Q24;
        else
            h32 = z_reg;
        hd33 = ({h32[31], h32} <<< 1) + 33'sd128;

        sum50 = {{2{progress_reg[47]}}, progress_reg} + {10'b0, delta_reg};
        if (sum50 > 50'sh0_7FFF_FFFF_FFFF)
            sat48 = 48'sh7FFF_FFFF_FFFF;
        else if (sum50 < -50'sh0_8000_0000_0000)
            sat48 = 48'sh8000_0000_0000;
        else
            sat48 = sum50[47:0];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            cnt_reg       <= '0;
            op_reg        <= '0;
            have_reg      <= 1'b0;
            progress_reg  <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            op_reg    <= op_next;
            if (wr_en)
                start_reg <= wr_data;
            if (accept)
            begin
                if (restart)
                begin
                    progress_reg <= {{16{start_reg[31]}}, start_reg};
                    have_reg     <= 1'b0;
                end
                else if (pose_valid)
                    have_reg <= 1'b1;
            end
            if (state_reg == S_ADD)
                progress_reg <= sat48;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_w;
        if (op_reg.en)
            acc_reg[op_reg.dst] <= acc_sum;

        if (accept)
        begin
            cq_reg   <= '{quat_w, quat_x, quat_y, quat_z};
            ct_reg   <= '{trans_x, trans_y, trans_z};
            pure_reg <= pure_translation;
            resv_reg <= restart || pose_valid;
            if (!restart && pose_valid && !have_reg)
            begin
                lq_reg <= '{quat_w, quat_x, quat_y, quat_z};
                lt_reg <= '{trans_x, trans_y, trans_z};
            end
        end

        case (state_reg)
            S_QRND:
                qr_reg[cnt_reg[1:0]] <= rnd16;
            S_RMAT:
            begin
                rs_reg[cnt_reg[3:0]] <= rr64[31:0];
                col_reg <= '0;
                row_reg <= '0;
            end
            S_TPROD:
            begin
                if (col_reg == 2'd2)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 2'd1;
                end
                else
                    col_reg <= col_reg + 2'd1;
            end
            S_TDIFF:
            begin
                m_reg[cnt_reg[1:0]] <= d40[39] ? nd40[38:0] : d40[38:0];
                s_reg <= '0;
            end
            S_NORM:
            begin
                if (any_high)
                begin
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                    s_reg    <= s_reg + 4'd1;
                end
            end
            S_CINIT:
            begin
                x_reg <= 40'({xa, 20'b0});
                y_reg <= 40'({root_val[18:0], 20'b0});
                z_reg <= '0;
            end
            S_CORDIC:
            begin
                // rotate towards y = 0, y = 0 counts as negative
                if (y_reg > 40'sd0)
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + cordic_angle(cnt_reg);
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - cordic_angle(cnt_reg);
                end
            end
            S_ANGLE:
                delta_reg <= 40'(hd33[32:8]);
            S_DIST:
                delta_reg <= 40'(root_val) << s_reg;
            S_ADD:
            begin
                lq_reg <= cq_reg;
                lt_reg <= ct_reg;
            end
            default:
            begin
            end
        endcase

        if (state_reg == S_DONE && out_free)
        begin
            est_valid_reg <= resv_reg;
            est_reg       <= resv_reg ? progress_reg : 48'sd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign estimate_valid = est_valid_reg;
    assign estimate       = est_reg;

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != S_IDLE)
        else $error("accepted transfer did not start a computation");

    a_root_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        root_done |-> state_reg == S_ROOT_WAIT)
        else $error("square root finished outside its wait state");

    a_acc_follows_issue: assert property (@(posedge clk) disable iff (!rst_n)
        op_reg.en |-> ($past(state_reg) == S_QMUL || $past(state_reg) == S_SQ ||
                       $past(state_reg) == S_RPROD || $past(state_reg) == S_TPROD ||
                       $past(state_reg) == S_TSQ))
        else $error("accumulate without a multiplier issue");

    a_cordic_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CORDIC |-> cnt_reg < 5'(CORDIC_STEPS))
        else $error("CORDIC step count overrun");
`endif

endmodule

/* bench/tb_pose_delta_progress_accumulator.sv */
// Self-checking testbench of the pose delta progress accumulator.
`timescale 1ns / 100ps

class progress_board;
    logic signed [47:0] want_est[$];
    logic               want_ok[$];
    int                 fails;
    int                 seen;

    // state mirrored from the block
    logic signed [31:0] start_val;
    logic               have_pose;
    logic signed [63:0] prev_q[4];
    logic signed [63:0] prev_t[3];
    logic signed [63:0] progress;

    function new();
        fails = 0;
        seen = 0;
        start_val = 0;
        have_pose = 0;
        progress = 0;
        foreach (prev_q[i]) prev_q[i] = 0;
        foreach (prev_t[i]) prev_t[i] = 0;
    endfunction

    static function logic signed [63:0] rnd_sat16(logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    static function logic [63:0] root_floor(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    static function logic signed [63:0] atan_step(int i);
        case (i)
            0: return 13176795;  1: return 7778716;  2: return 4110060;
            3: return 2086331;   4: return 1047214;  5: return 524117;
            6: return 262123;    7: return 131069;
            default: return 64'sd65536 >>> (i - 8);
        endcase
    endfunction

    static function logic signed [63:0] half_angle(logic signed [63:0] xa,
                                                   logic signed [63:0] ya);
        logic signed [63:0] x, y, z, xs, ys;
        if (ya == 0) return 0;
        if (xa == 0) return 26353589;
        x = xa <<< 20;
        y = ya <<< 20;
        z = 0;
        for (int i = 0; i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z = z + atan_step(i);
            end
            else
            begin
                x = x - ys; y = y + xs; z = z - atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > 26353589) z = 26353589;
        return z;
    endfunction

    function logic signed [63:0] step_size(logic signed [63:0] cq[4],
                                           logic signed [63:0] ct[3], logic trans_only);
        logic signed [63:0] aw, ax, ay, az, bw, bx, by, bz, w, x, y, z, acc;
        logic signed [63:0] r[3][3];
        logic [63:0] m[3];
        logic signed [63:0] d;
        int s;
        aw = prev_q[0]; ax = prev_q[1]; ay = prev_q[2]; az = prev_q[3];
        bw = cq[0]; bx = -cq[1]; by = -cq[2]; bz = -cq[3];
        w = rnd_sat16(aw*bw - ax*bx - ay*by - az*bz);
        x = rnd_sat16(aw*bx + ax*bw + ay*bz - az*by);
        y = rnd_sat16(aw*by - ax*bz + ay*bw + az*bx);
        z = rnd_sat16(aw*bz + ax*by - ay*bx + az*bw);
        if (!trans_only)
            return (2 * half_angle(w < 0 ? -w : w, root_floor(x*x + y*y + z*z)) + 128)
                   >>> 8;
        r[0][0] = (64'sd1 <<< 30) - 2*(y*y + z*z);
        r[0][1] = 2*(x*y - w*z);
        r[0][2] = 2*(x*z + w*y);
        r[1][0] = 2*(x*y + w*z);
        r[1][1] = (64'sd1 <<< 30) - 2*(x*x + z*z);
        r[1][2] = 2*(y*z - w*x);
        r[2][0] = 2*(x*z - w*y);
        r[2][1] = 2*(y*z + w*x);
        r[2][2] = (64'sd1 <<< 30) - 2*(x*x + y*y);
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc = acc + ((r[i][j] + 4) >>> 3) * ct[j];
            d = prev_t[i] - ((acc + (64'sd1 <<< 26)) >>> 27);
            m[i] = d < 0 ? -d : d;
        end
        s = 0;
        while (m[0] >= 64'd2147483648 || m[1] >= 64'd2147483648 ||
               m[2] >= 64'd2147483648)
        begin
            m[0] = m[0] >> 1; m[1] = m[1] >> 1; m[2] = m[2] >> 1;
            s++;
        end
        return root_floor(m[0]*m[0] + m[1]*m[1] + m[2]*m[2]) << s;
    endfunction

    function void note_pose(logic rs, logic pv, logic pt, logic signed [63:0] cq[4],
                            logic signed [63:0] ct[3]);
        logic signed [63:0] p;
        if (rs)
        begin
            progress = start_val;
            have_pose = 0;
        end
        else if (!pv)
        begin
            want_ok.push_back(0);
            want_est.push_back(0);
            return;
        end
        else
        begin
            if (have_pose)
            begin
                p = progress + step_size(cq, ct, pt);
                if (p > 64'sh7FFFFFFFFFFF) p = 64'sh7FFFFFFFFFFF;
                if (p < -64'sh800000000000) p = -64'sh800000000000;
                progress = p;
            end
            prev_q = cq;
            prev_t = ct;
            have_pose = 1;
        end
        want_ok.push_back(1);
        want_est.push_back(progress[47:0]);
    endfunction

    function void check_estimate(logic ok, logic signed [47:0] est);
        logic e_ok;
        logic signed [47:0] e_est;
        seen++;
        if (want_ok.size() == 0)
        begin
            $error("unexpected result: estimate_valid %0d estimate %0d", ok, est);
            fails++;
            return;
        end
        e_ok = want_ok.pop_front();
        e_est = want_est.pop_front();
        if (ok !== e_ok)
        begin
            $error("estimate_valid: expected %0d, got %0d", e_ok, ok);
            fails++;
        end
        if (est !== e_est)
        begin
            $error("estimate: expected %0d, got %0d", e_est, est);
            fails++;
        end
    endfunction
endclass

module tb_pose_delta_progress_accumulator;
    logic clk = 0;
    logic rst_n = 0;
    logic wr_en = 0;
    logic signed [31:0] wr_data = 0;
    logic in_valid = 0;
    logic in_stall;
    logic restart = 0, pose_valid = 0, pure_translation = 0;
    logic signed [15:0] quat_w = 0, quat_x = 0, quat_y = 0, quat_z = 0;
    logic signed [31:0] trans_x = 0, trans_y = 0, trans_z = 0;
    logic out_valid;
    logic out_stall = 0;
    logic estimate_valid;
    logic signed [47:0] estimate;

    progress_board board;
    bit calm = 0;
    int idle_cycles = 0;
    int sent = 0;

    always #5 clk = ~clk;

    pose_delta_progress_accumulator dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_data(wr_data),
        .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
        .pose_valid(pose_valid), .pure_translation(pure_translation),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .estimate_valid(estimate_valid), .estimate(estimate)
    );

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_estimate(estimate_valid, estimate);
        if (rst_n)
            out_stall <= calm ? 1'b0 : ($urandom_range(99) < 24);
    end

    // watchdog: cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays high after a transfer until the next idle gap or drain
    task automatic send_pose(logic rs, logic pv, logic pt,
                             logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z,
                             logic signed [31:0] tx, logic signed [31:0] ty,
                             logic signed [31:0] tz);
        logic signed [63:0] cq[4];
        logic signed [63:0] ct[3];
        while (!calm && $urandom_range(99) < 24)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        restart <= rs; pose_valid <= pv; pure_translation <= pt;
        quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
        trans_x <= tx; trans_y <= ty; trans_z <= tz;
        in_valid <= 1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        cq[0] = w; cq[1] = x; cq[2] = y; cq[3] = z;
        ct[0] = tx; ct[1] = ty; ct[2] = tz;
        board.note_pose(rs, pv, pt, cq, ct);
        sent++;
    endtask

    task automatic drain_and_set(logic signed [31:0] v);
        in_valid <= 0;
        while (board.want_ok.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        wr_en <= 1;
        wr_data <= v;
        @(posedge clk);
        wr_en <= 0;
        board.start_val = v;
    endtask

    // a quaternion with one large component of random sign and small others
    task automatic rand_pose(logic pt, int big);
        logic signed [15:0] q[4];
        int n;
        n = $urandom_range(3);
        foreach (q[i]) q[i] = (i == n) ? 16'($urandom_range(32767, 20000)) : 16'sd0;
        foreach (q[i]) if (i != n) q[i] = 16'($signed(16'($urandom_range(16383))) - 8191);
        if ($urandom_range(1)) q[n] = -q[n];
        if (big)
            send_pose(0, 1, pt, q[0], q[1], q[2], q[3], $urandom, $urandom, $urandom);
        else
            send_pose(0, 1, pt, q[0], q[1], q[2], q[3],
                      $signed($urandom_range(2000000)) - 1000000,
                      $signed($urandom_range(2000000)) - 1000000,
                      $signed($urandom_range(2000000)) - 1000000);
    endtask

    initial
    begin
        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed part
        send_pose(0, 1, 0, 32767, 0, 0, 0, 0, 0, 0);
        send_pose(0, 1, 0, 0, 32767, 0, 0, 65536, 0, 0);
        send_pose(0, 1, 1, 23170, 0, 23170, 0, 0, 65536, 0);
        send_pose(0, 0, 1, 1, 2, 3, 4, 5, 6, 7);
        send_pose(0, 1, 1, -32768, -32768, -32768, -32768,
                  32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_pose(0, 1, 1, 32767, 32767, 32767, 32767,
                  32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_pose(0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(0, 1, 0, -32768, 0, 0, 0, -1, -1, -1);
        send_pose(1, 0, 0, -1, -1, -1, -1, -1, -1, -1);
        send_pose(0, 1, 1, 32767, 0, 0, 0, 0, 0, 0);
        drain_and_set(32'sh7FFFFFFF);
        send_pose(1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        send_pose(0, 1, 1, 32767, 0, 0, 0, 32'sh80000000, 32'sh80000000, 0);
        send_pose(0, 1, 1, 32767, 0, 0, 0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        drain_and_set(32'sh80000000);
        send_pose(1, 0, 1, 0, 0, 0, 0, 0, 0, 0);
        send_pose(0, 1, 0, 32767, 0, 0, 0, 0, 0, 0);
        send_pose(0, 1, 0, 0, 0, 0, 32767, 0, 0, 0);

        // random part in phases, each with its own start value
        for (int ph = 0; ph < 7; ph++)
        begin
            calm = (ph == 3);
            drain_and_set(ph == 6 ? 32'sh7FFFFFFF : $urandom);
            for (int k = 0; k < 200; k++)
            begin
                if ($urandom_range(99) < 5)
                    send_pose(1, 1'($urandom), 1'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom),
                              $urandom, $urandom, $urandom);
                else if ($urandom_range(99) < 8)
                    send_pose(0, 0, 1'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom),
                              $urandom, $urandom, $urandom);
                else if ($urandom_range(99) < 10)
                    send_pose(0, 1, 1'($urandom), 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom),
                              $urandom, $urandom, $urandom);
                else
                    rand_pose(1'($urandom), ph == 6 || $urandom_range(99) < 10);
            end
        end
        calm = 0;
        in_valid <= 0;

        while (board.want_ok.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        $display("covered %0d poses and %0d results over restarts, invalid poses,",
                 sent, board.seen);
        $display("rotation and distance steps and several start values");
        if (board.fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
